>>> hdl/xcfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types, codes and sizes for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam int ByteW   = 8;
	localparam int EventW  = 3;
	localparam int CfgIdxW = 8;

	// Decoupling queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = CfgIdxW'(1);

	localparam logic [ByteW-1:0] SyncFirstRst  = ByteW'(76);
	localparam logic [ByteW-1:0] SyncSecondRst = ByteW'(0);

	typedef enum logic [EventW-1:0] {
		EV_NONE    = 3'd0,
		EV_LENGTH  = 3'd1,
		EV_PAYLOAD = 3'd2,
		EV_GOOD    = 3'd3,
		EV_ERROR   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		PH_HUNT1 = 2'd0,
		PH_HUNT2 = 2'd1,
		PH_BODY  = 2'd2,
		PH_CHECK = 2'd3
	} phase_t;

	// Classified byte handed from front to back
	typedef struct packed {
		logic [ByteW-1:0] rx_byte;
		logic             match_first;
		logic             match_second;
	} item_t;

	typedef struct packed {
		logic [EventW-1:0] event_res;
		logic [ByteW-1:0]  data_byte;
		logic [ByteW-1:0]  payload_index;
	} result_t;

endpackage

>>> hdl/xcfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfd interfaces
// Valid/ready channels for received bytes, events and configuration writes.
// ----------------------------------------------------------------------------
interface xcfd_rx_if import xcfd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfd_ev_if import xcfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [EventW-1:0] event_res;
	logic [ByteW-1:0]  data_byte;
	logic [ByteW-1:0]  payload_index;

	modport source (output valid, output event_res, output data_byte,
		output payload_index, input ready);
	modport sink   (input valid, input event_res, input data_byte,
		input payload_index, output ready);
endinterface

interface xcfd_cfg_if import xcfd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [ByteW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/xor_checked_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Path: a byte transfers into the front register, then into the queue, and
// its event is then offered from the event register.
// Throughput: one byte per cycle while ev.ready holds; the back state machine
// takes one queued byte per cycle when the event register is free or drained.
// Reset: arst_n clears the phase to hunting the first sync byte, the XOR, the
// counters and all valid flags, and loads the sync registers with 76 and 0.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer import xcfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	xcfd_rx_if.sink    rx,
	xcfd_cfg_if.sink   cfg,
	xcfd_ev_if.source  ev
);

	// Front to queue
	item_t            front_item_s1;
	logic             front_valid_s1;
	logic             q_in_ready;

	// Queue to back
	item_t            q_item;
	logic             q_valid;
	logic             back_ready;
	logic [QCntW-1:0] q_level;

	// Front: transfer bytes in, classify them against the sync registers and
	// own the configuration registers. Sync compares happen here so the back
	// state machine only sees two match flags.
	xcfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.item_s1  (front_item_s1),
		.valid_s1 (front_valid_s1),
		.q_ready  (q_in_ready)
	);

	// Queue: absorb a stall on the event side without halting the front.
	xcfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (front_item_s1),
		.in_valid  (front_valid_s1),
		.in_ready  (q_in_ready),
		.out_item  (q_item),
		.out_valid (q_valid),
		.out_ready (back_ready),
		.level     (q_level)
	);

	// Back: advance the frame phase, count bytes, fold payload into the XOR
	// and register exactly one event per byte.
	xcfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (q_item),
		.in_valid (q_valid),
		.in_ready (back_ready),
		.ev       (ev)
	);

	// Queue never holds more entries than it has.
	a_q_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QCntW'(QDepth))
		else $error("deframer queue overfilled");

	// Only payload events carry an index.
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && (ev.event_res != EV_PAYLOAD) |-> (ev.payload_index == '0))
		else $error("payload index on non-payload event");

	// Data byte is only carried by length and payload events.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && (ev.event_res != EV_PAYLOAD) && (ev.event_res != EV_LENGTH)
		|-> (ev.data_byte == '0))
		else $error("data byte on event that carries none");

	// Event codes stay within the defined range.
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |-> (ev.event_res <= EV_ERROR))
		else $error("undefined event code");

endmodule

>>> hdl/xcfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfd_front
// Accept bytes, compare against the sync registers, register the result.
// ----------------------------------------------------------------------------
module xcfd_front import xcfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	xcfd_rx_if.sink       rx,
	xcfd_cfg_if.sink      cfg,
	output item_t         item_s1,
	output logic          valid_s1,
	input  logic          q_ready
);

	logic [ByteW-1:0] sync_first_q;
	logic [ByteW-1:0] sync_second_q;
	logic             rx_take;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !valid_s1 || q_ready;
	assign rx_take   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SyncFirstRst;
			sync_second_q <= SyncSecondRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg.data;
				CFG_SYNC_SECOND: sync_second_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			item_s1.rx_byte      <= rx.rx_byte;
			item_s1.match_first  <= (rx.rx_byte == sync_first_q);
			item_s1.match_second <= (rx.rx_byte == sync_second_q);
		end
	end

endmodule

>>> hdl/xcfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfd_queue
// Short register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module xcfd_queue import xcfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            in_item,
	input  logic             in_valid,
	output logic             in_ready,
	output item_t            out_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [QCntW-1:0] level
);

	item_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q < QCntW'(QDepth));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign level     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

>>> hdl/xcfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfd_back
// Frame state machine: track phase, count and XOR, register one event per byte.
// ----------------------------------------------------------------------------
module xcfd_back import xcfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  item_t    in_item,
	input  logic     in_valid,
	output logic     in_ready,
	xcfd_ev_if.source ev
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] xor_q, xor_d;
	logic [ByteW-1:0] count_q, count_d;
	logic [ByteW-1:0] length_q, length_d;
	result_t          res_q, res_d;
	logic             ev_valid_q;
	logic             take;
	logic [ByteW-1:0] count_inc;
	logic [ByteW-1:0] length_eff;
	logic             first_body;

	assign in_ready   = !ev_valid_q || ev.ready;
	assign take       = in_valid && in_ready;
	assign first_body = (count_q == '0);
	assign count_inc  = count_q + 1'b1;
	// the length byte is compared in the same step it is captured
	assign length_eff = first_body ? in_item.rx_byte : length_q;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT1: phase_d = in_item.match_first ? PH_HUNT2 : PH_HUNT1;
			PH_HUNT2: phase_d = in_item.match_second ? PH_BODY : PH_HUNT1;
			PH_BODY:  phase_d = (count_inc == length_eff) ? PH_CHECK : PH_BODY;
			PH_CHECK: phase_d = PH_HUNT1;
			default:  phase_d = PH_HUNT1;
		endcase
	end

	always_comb begin
		xor_d    = xor_q;
		count_d  = count_q;
		length_d = length_q;
		res_d    = '{event_res: EV_NONE, data_byte: '0, payload_index: '0};
		case (phase_q)
			PH_HUNT1: begin
				if (!in_item.match_first) begin
					res_d.event_res = EV_ERROR;
				end
			end
			PH_HUNT2: begin
				if (in_item.match_second) begin
					xor_d   = '0;
					count_d = '0;
				end else begin
					res_d.event_res = EV_ERROR;
				end
			end
			PH_BODY: begin
				res_d.data_byte = in_item.rx_byte;
				count_d         = count_inc;
				if (first_body) begin
					length_d        = in_item.rx_byte;
					res_d.event_res = EV_LENGTH;
				end else begin
					xor_d               = xor_q ^ in_item.rx_byte;
					res_d.event_res     = EV_PAYLOAD;
					res_d.payload_index = count_q - 1'b1;
				end
			end
			PH_CHECK: begin
				res_d.event_res = (in_item.rx_byte == xor_q) ? EV_GOOD : EV_ERROR;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT1;
			xor_q      <= '0;
			count_q    <= '0;
			length_q   <= '0;
			ev_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q    <= phase_d;
				xor_q      <= xor_d;
				count_q    <= count_d;
				length_q   <= length_d;
				ev_valid_q <= 1'b1;
			end else if (ev.ready) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign ev.valid         = ev_valid_q;
	assign ev.event_res     = res_q.event_res;
	assign ev.data_byte     = res_q.data_byte;
	assign ev.payload_index = res_q.payload_index;

endmodule
